// ===== rtl/fcba_pkg.sv =====
// ----------------------------------------------------------------------------
// fcba_pkg
// Shared types and constants for the chained block allocator.
// ----------------------------------------------------------------------------
package fcba_pkg;

  localparam int unsigned DEFAULT_BLOCK_COUNT = 256;
  localparam int unsigned LINK_W              = 8;
  localparam int unsigned ENTRY_W             = LINK_W + 1;

  // One link table entry: all zero is a free block
  typedef struct packed {
    logic              end_flag;
    logic [LINK_W-1:0] link;
  } entry_t;

  localparam entry_t ENTRY_FREE = '{end_flag: 1'b0, link: '0};
  localparam entry_t ENTRY_END  = '{end_flag: 1'b1, link: '0};

  typedef enum logic [1:0] {
    REQ_ALLOC      = 2'd0,
    REQ_ALLOC_LINK = 2'd1,
    REQ_FREE_CHAIN = 2'd2,
    REQ_NEXT       = 2'd3
  } req_t;

endpackage

// ===== rtl/fcba_ram.sv =====
// ----------------------------------------------------------------------------
// fcba_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fcba_table.sv =====
// ----------------------------------------------------------------------------
// fcba_table
// Link table: RAM plus one valid bit per entry, so that reset gives
// block 0 as end of chain and every other block as free.
// ----------------------------------------------------------------------------
module fcba_table
  import fcba_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_BLOCK_COUNT,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_entry,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_entry
);

  logic [DEPTH-1:0] valid;
  logic             rd_valid;
  logic             rd_zero;
  logic [ENTRY_W-1:0] ram_rdata;

  fcba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
    if (rd_en) begin
      rd_valid <= valid[rd_addr];
      rd_zero  <= (rd_addr == '0);
    end
  end

  // Unwritten entries read as their reset value
  always_comb begin
    if (rd_valid) begin
      rd_entry = entry_t'(ram_rdata);
    end else if (rd_zero) begin
      rd_entry = ENTRY_END;
    end else begin
      rd_entry = ENTRY_FREE;
    end
  end

endmodule

// ===== rtl/fat_chain_block_allocator.sv =====
// ----------------------------------------------------------------------------
// fat_chain_block_allocator
// Block allocator over a table of next-block links, one request at a time.
// ----------------------------------------------------------------------------
// Allocate scans the table one entry per cycle; free-chain reads and checks
// each block it walks; next-link lookup reads the entry, checks it and then
// finishes. One request at a time: the next is taken once the result is loaded
// into the output register and the block is back in idle.
// Reset: the table valid bits clear; no clearing pass.
module fat_chain_block_allocator
  import fcba_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT = DEFAULT_BLOCK_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [LINK_W-1:0] block,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [LINK_W-1:0] result_block,
  output logic              end_of_chain,
  output logic              status
);

  localparam int unsigned DEPTH = (BLOCK_COUNT < 256) ? BLOCK_COUNT : 256;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LINK_W:0] DEPTH_L = (LINK_W + 1)'(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LINK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_LOOK_RD,
    ST_LOOK_CHK,
    ST_FINISH
  } state_t;

  state_t            state;
  req_t              req_q;
  logic [LINK_W-1:0] blk_q;
  logic [LINK_W:0]   scan_addr;
  logic              scan_pend;
  logic [AW-1:0]     pend_addr;
  logic [LINK_W-1:0] cur;
  logic [LINK_W:0]   steps;
  logic [LINK_W-1:0] res_q;
  logic              eoc_q;
  logic              st_q;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_entry;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_entry;
  logic          found;
  logic          blk_in_range;
  logic          in_blk_in_range;
  logic          cur_in_range;

  fcba_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  assign in_ready        = (state == ST_IDLE);
  assign blk_in_range    = ({1'b0, blk_q} < DEPTH_L);
  assign in_blk_in_range = ({1'b0, block} < DEPTH_L);
  assign cur_in_range    = ({1'b0, cur} < DEPTH_L);
  assign found           = (state == ST_SCAN) && scan_pend && (rd_entry == ENTRY_FREE);

  // Table port control
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = scan_addr[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = pend_addr;
    wr_entry = ENTRY_END;
    unique case (state)
      ST_SCAN: begin
        rd_en = (scan_addr < DEPTH_L) && !found;
        wr_en = found;
      end
      ST_LINK: begin
        wr_en    = 1'b1;
        wr_addr  = blk_q[AW-1:0];
        wr_entry = '{end_flag: 1'b0, link: res_q};
      end
      ST_WALK_RD: begin
        rd_en   = (steps < DEPTH_L) && cur_in_range;
        rd_addr = cur[AW-1:0];
      end
      ST_WALK_CHK: begin
        wr_en    = 1'b1;
        wr_addr  = cur[AW-1:0];
        wr_entry = ENTRY_FREE;
      end
      ST_LOOK_RD: begin
        rd_en   = 1'b1;
        rd_addr = blk_q[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      scan_pend <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_q     <= req_t'(req_type);
            blk_q     <= block;
            cur       <= block;
            steps     <= '0;
            scan_addr <= (LINK_W + 1)'(1);
            scan_pend <= 1'b0;
            res_q     <= '0;
            eoc_q     <= 1'b0;
            st_q      <= 1'b0;
            unique case (req_t'(req_type)) inside
              REQ_ALLOC, REQ_ALLOC_LINK: state <= ST_SCAN;
              REQ_FREE_CHAIN: state <= in_blk_in_range ? ST_WALK_RD : ST_FINISH;
              REQ_NEXT:       state <= in_blk_in_range ? ST_LOOK_RD : ST_FINISH;
            endcase
          end
        end
        ST_SCAN: begin
          // Reads are pipelined: the entry checked belongs to the previous address
          scan_pend <= rd_en;
          pend_addr <= scan_addr[AW-1:0];
          if (rd_en) begin
            scan_addr <= scan_addr + 1'b1;
          end
          if (found) begin
            res_q <= LINK_W'(pend_addr);
            if (req_q == REQ_ALLOC_LINK && blk_in_range) begin
              state <= ST_LINK;
            end else begin
              state <= ST_FINISH;
            end
          end else if (!scan_pend && scan_addr >= DEPTH_L) begin
            st_q  <= 1'b1;
            state <= ST_FINISH;
          end
        end
        ST_LINK: begin
          state <= ST_FINISH;
        end
        ST_WALK_RD: begin
          state <= rd_en ? ST_WALK_CHK : ST_FINISH;
        end
        ST_WALK_CHK: begin
          // Stop at a free or end-of-chain entry, else follow the link
          if (rd_entry == ENTRY_FREE || rd_entry.end_flag) begin
            state <= ST_FINISH;
          end else begin
            cur   <= rd_entry.link;
            steps <= steps + 1'b1;
            state <= ST_WALK_RD;
          end
        end
        ST_LOOK_RD: begin
          state <= ST_LOOK_CHK;
        end
        ST_LOOK_CHK: begin
          if (rd_entry.end_flag) begin
            eoc_q <= 1'b1;
          end else begin
            res_q <= rd_entry.link;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          // Hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            result_block <= res_q;
            end_of_chain <= eoc_q;
            status       <= st_q;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
